### sv/cprt_pkg.sv
// Shared types and constants of the CIDR prefix range table.
`default_nettype none
package cprt_pkg;

    // Operation codes of an input word
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Maximum prefix lengths per family
    localparam logic [7:0] V4_LEN = 8'd32;
    localparam logic [7:0] V6_LEN = 8'd128;

    localparam logic [31:0]  V4_ONES  = 32'hFFFF_FFFF;
    localparam logic [127:0] V6_ONES  = {128{1'b1}};

    // One stored range: family bit plus inclusive 128-bit bounds
    typedef struct packed {
        logic         family;
        logic [127:0] rng_start;
        logic [127:0] rng_end;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage : cprt_pkg
`default_nettype wire

### sv/cprt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cprt_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule : cprt_ram
`default_nettype wire

### sv/cidr_prefix_range_table_unit.sv
// An insert passes through the insert and response states; a lookup reads one stored entry per
// cycle, folding each compare into the hit flag; the result loads once the output is free.
// One word is handled at a time through the single read port of the range RAM; the next word
// is accepted the cycle after the result loads.
// The result register lets the next word be accepted while the last result waits.
// Reset (aresetn, synchronous, active low) clears the fill count; the RAM is not cleared.
`default_nettype none
module cidr_prefix_range_table_unit #(
    parameter int ENTRIES = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input word channel
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_op,
    input  wire logic         s_is_v6,
    input  wire logic [63:0]  s_addr_hi,
    input  wire logic [63:0]  s_addr_lo,
    input  wire logic [7:0]   s_prefix_len,
    // result word channel
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_hit,
    output logic [1:0]        m_status
);
    import cprt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);

    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic            hit_reg, hit_next;
    logic [1:0]      status_reg, status_next;
    logic            op_reg, op_next;
    logic            v6_reg, v6_next;
    logic [127:0]    addr_reg, addr_next;
    logic [7:0]      len_reg, len_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_hit_reg, m_hit_next;
    logic [1:0]      m_status_reg, m_status_next;

    logic            ram_we;
    logic            ram_re;
    entry_t          wr_entry;
    entry_t          rd_entry;
    logic [127:0]    host_mask;
    logic            bad_len;
    logic            is_full;
    logic            match;
    logic            load_out;

    // range store
    cprt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    // insert datapath: length check and host-bit mask
    always_comb begin
        bad_len   = (len_reg == 8'd0) || (len_reg > (v6_reg ? V6_LEN : V4_LEN));
        is_full   = (fill_reg == FW'(ENTRIES));
        host_mask = v6_reg ? (V6_ONES >> len_reg) : {96'd0, V4_ONES >> len_reg};
        wr_entry.family    = v6_reg;
        wr_entry.rng_start = addr_reg & ~host_mask;
        wr_entry.rng_end   = addr_reg | host_mask;
    end

    // lookup compare against the entry read last cycle
    assign match = (rd_entry.family == v6_reg) &&
                   (rd_entry.rng_start <= addr_reg) &&
                   (addr_reg <= rd_entry.rng_end);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        op_next       = op_reg;
        v6_next       = v6_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_hit_next    = m_hit_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        load_out      = 1'b0;
        s_ready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next     = s_op;
                    v6_next     = s_is_v6;
                    addr_next   = s_is_v6 ? {s_addr_hi, s_addr_lo}
                                          : {96'd0, s_addr_lo[31:0]};
                    len_next    = s_prefix_len;
                    hit_next    = 1'b0;
                    status_next = STATUS_OK;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = (s_op == OP_INSERT) ? ST_INSERT : ST_SCAN;
                end
            end
            ST_INSERT: begin
                if (bad_len) begin
                    status_next = STATUS_BAD_LEN;
                end else if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + FW'(1);
                end
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                // fold in the entry read in the previous cycle
                hit_next = hit_reg | (pend_reg & match);
                if (idx_reg < fill_reg) begin
                    ram_re    = 1'b1;
                    idx_next  = idx_reg + FW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    load_out      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_hit_next    = hit_reg;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        op_reg       <= op_next;
        v6_reg       <= v6_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        m_hit_reg    <= m_hit_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_hit    = m_hit_reg;
    assign m_status = m_status_reg;

    // the fill count never passes the table size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(ENTRIES))
        else $error("fill count beyond table size");

    // a successful insert grows the table by exactly one
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSERT && !bad_len && !is_full) |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("insert did not advance fill count");

    // a scan only reads written entries
    a_scan_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> idx_reg < fill_reg)
        else $error("scan read beyond fill count");

    // lookups always report ok status; inserts never report a hit
    a_lookup_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && op_reg == OP_LOOKUP) |=> m_status == STATUS_OK)
        else $error("lookup reported non-ok status");

    a_insert_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && op_reg == OP_INSERT) |=> !m_hit)
        else $error("insert reported a hit");

endmodule : cidr_prefix_range_table_unit
`default_nettype wire
